FILE: rtl/rbsi_pkg.sv
// Package for the ray versus box slab intersection block.
// Holds the number format, the divider latency and the divider side-band type.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package rbsi_pkg;

   // Signed fixed point format of every coordinate and distance.
   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;

   // Integer bits of the format; the overflow precheck needs it above zero.
   localparam int INT_BITS = COORD_WIDTH - FRAC_BITS;

   // One setup stage, one stage per quotient bit and one finishing stage.
   localparam int DIV_LATENCY = COORD_WIDTH + 2;

   // Whole pipeline: divider stages and the min/max output stage.
   localparam int PIPE_DEPTH = DIV_LATENCY + 1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic        [COORD_WIDTH-1:0] ord_type;

   // Offset binary limits: most negative and most positive values, and zero.
   localparam ord_type ORD_MIN  = '0;
   localparam ord_type ORD_MAX  = '1;
   localparam ord_type ORD_HALF = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   // Facts about one division that travel beside the remainder.
   typedef struct packed {
      logic    neg;
      logic    nneg;
      logic    dzero;
      logic    nzero;
      logic    ovf;
      logic    is_max;
      ord_type dmag;
   } div_side_type;

endpackage

FILE: rtl/rbsi_slab_div.sv
// One slab distance: (corner - origin) / dir in fixed point, saturated,
// returned in offset binary form. Restoring division, one quotient bit a stage.
// Depends on rbsi_pkg.
`timescale 1ns / 1ps

module rbsi_slab_div (
   input  logic                clock,
   input  logic                en,
   input  logic                is_max,
   input  rbsi_pkg::coord_type corner,
   input  rbsi_pkg::coord_type orig,
   input  rbsi_pkg::coord_type dir,
   output rbsi_pkg::ord_type   slab_t
);
   import rbsi_pkg::*;

   // Setup stage: numerator and divisor magnitudes, signs and early checks.
   ord_type                     a_ord;
   ord_type                     b_ord;
   logic                        nneg_in;
   ord_type                     nmag_in;
   logic                        dneg_in;
   ord_type                     dmag_in;
   logic [2*COORD_WIDTH-FRAC_BITS-1:0] ovf_num;
   logic [2*COORD_WIDTH-FRAC_BITS-1:0] ovf_den;
   div_side_type                side_in;

   always_comb begin
      a_ord   = ord_type'(corner) ^ ORD_HALF;
      b_ord   = ord_type'(orig) ^ ORD_HALF;
      nneg_in = a_ord < b_ord;
      nmag_in = nneg_in ? (b_ord - a_ord) : (a_ord - b_ord);
      dneg_in = dir[COORD_WIDTH-1];
      dmag_in = dneg_in ? (ord_type'(0) - ord_type'(dir)) : ord_type'(dir);
      // Quotient reaches 2^COORD_WIDTH when nmag >= dmag * 2^INT_BITS.
      ovf_num = {{INT_BITS{1'b0}}, nmag_in};
      ovf_den = {dmag_in, {INT_BITS{1'b0}}};
      side_in.neg    = nneg_in != dneg_in;
      side_in.nneg   = nneg_in;
      side_in.dzero  = dmag_in == '0;
      side_in.nzero  = nmag_in == '0;
      side_in.ovf    = ovf_num >= ovf_den;
      side_in.is_max = is_max;
      side_in.dmag   = dmag_in;
   end

   // Per-stage registers; index 0 is the setup stage output.
   div_side_type side_ff [0:COORD_WIDTH];
   ord_type      rem_ff  [0:COORD_WIDTH];
   ord_type      low_ff  [0:COORD_WIDTH];
   ord_type      quo_ff  [0:COORD_WIDTH];

   // Initial remainder holds the numerator bits above the quotient window.
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         rem_ff[0]  <= nmag_in >> INT_BITS;
         low_ff[0]  <= {nmag_in[INT_BITS-1:0], {FRAC_BITS{1'b0}}};
         quo_ff[0]  <= '0;
      end
   end

   // One restoring step per stage, most significant quotient bit first.
   genvar k;
   generate
      for (k = 0; k < COORD_WIDTH; k++) begin : g_step
         logic [COORD_WIDTH:0] trial;
         logic                 fits;

         always_comb begin
            trial = {rem_ff[k], low_ff[k][COORD_WIDTH-1]};
            fits  = trial >= {1'b0, side_ff[k].dmag};
         end

         always_ff @(posedge clock) begin
            if (en) begin
               side_ff[k+1] <= side_ff[k];
               rem_ff[k+1]  <= fits ? COORD_WIDTH'(trial - {1'b0, side_ff[k].dmag})
                                    : trial[COORD_WIDTH-1:0];
               low_ff[k+1]  <= {low_ff[k][COORD_WIDTH-2:0], 1'b0};
               quo_ff[k+1]  <= {quo_ff[k][COORD_WIDTH-2:0], fits};
            end
         end
      end
   endgenerate

   // Finishing stage: special cases, saturation and offset binary result.
   div_side_type fin;
   ord_type      q;
   ord_type      lim;
   ord_type      dist_in;
   ord_type      dist_ff;

   always_comb begin
      fin = side_ff[COORD_WIDTH];
      q   = quo_ff[COORD_WIDTH];
      lim = fin.neg ? ORD_HALF : (ORD_HALF - ord_type'(1));
      if (fin.dzero) begin
         if (fin.nzero) begin
            dist_in = fin.is_max ? ORD_MAX : ORD_MIN;
         end else begin
            dist_in = fin.nneg ? ORD_MIN : ORD_MAX;
         end
      end else if (fin.ovf || (q > lim)) begin
         dist_in = fin.neg ? ORD_MIN : ORD_MAX;
      end else begin
         dist_in = fin.neg ? (ORD_HALF - q) : (ORD_HALF + q);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dist_ff <= dist_in;
      end
   end

   assign slab_t = dist_ff;

endmodule

FILE: rtl/ray_box_slab_intersect.sv
// Top level of the ray versus axis-aligned box slab test.
// Six slab dividers feed one min/max stage; depends on rbsi_pkg and rbsi_slab_div.
//
//   channel | ports                                   | direction
//   req     | req_valid/req_ready, origin, dir, box   | in
//   rsp     | rsp_valid/rsp_ready, t_near, t_far      | out
//
// One transfer is accepted every cycle while the output is not stalled; the
// depth of PIPE_DEPTH registers at Q16.16 is set by the one-bit-per-stage restoring dividers.
// Synchronous reset clears only the valid bits of the pipeline.
// A stall at the output freezes the whole pipeline; nothing is lost or repeated.
`timescale 1ns / 1ps

module ray_box_slab_intersect (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  rbsi_pkg::coord_type req_origin_x,
   input  rbsi_pkg::coord_type req_origin_y,
   input  rbsi_pkg::coord_type req_origin_z,
   input  rbsi_pkg::coord_type req_dir_x,
   input  rbsi_pkg::coord_type req_dir_y,
   input  rbsi_pkg::coord_type req_dir_z,
   input  rbsi_pkg::coord_type req_box_min_x,
   input  rbsi_pkg::coord_type req_box_min_y,
   input  rbsi_pkg::coord_type req_box_min_z,
   input  rbsi_pkg::coord_type req_box_max_x,
   input  rbsi_pkg::coord_type req_box_max_y,
   input  rbsi_pkg::coord_type req_box_max_z,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rbsi_pkg::coord_type rsp_t_near,
   output rbsi_pkg::coord_type rsp_t_far
);
   import rbsi_pkg::*;

   // The pipeline advances whenever the last stage is empty or drained.
   logic en;
   logic valid_ff [0:PIPE_DEPTH-1];

   assign en        = !valid_ff[PIPE_DEPTH-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = valid_ff[PIPE_DEPTH-1];

   // Valid bits travel beside the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= req_valid;
         for (int i = 1; i < PIPE_DEPTH; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // Per axis: entry and exit corners share origin and direction.
   coord_type org  [0:2];
   coord_type dirv [0:2];
   coord_type cmin [0:2];
   coord_type cmax [0:2];
   ord_type   t0   [0:2];
   ord_type   t1   [0:2];

   always_comb begin
      org[0]  = req_origin_x;
      org[1]  = req_origin_y;
      org[2]  = req_origin_z;
      dirv[0] = req_dir_x;
      dirv[1] = req_dir_y;
      dirv[2] = req_dir_z;
      cmin[0] = req_box_min_x;
      cmin[1] = req_box_min_y;
      cmin[2] = req_box_min_z;
      cmax[0] = req_box_max_x;
      cmax[1] = req_box_max_y;
      cmax[2] = req_box_max_z;
   end

   genvar ax;
   generate
      for (ax = 0; ax < 3; ax++) begin : g_axis
         rbsi_slab_div u_div_min (
            .clock  (clock),
            .en     (en),
            .is_max (1'b0),
            .corner (cmin[ax]),
            .orig   (org[ax]),
            .dir    (dirv[ax]),
            .slab_t (t0[ax])
         );
         rbsi_slab_div u_div_max (
            .clock  (clock),
            .en     (en),
            .is_max (1'b1),
            .corner (cmax[ax]),
            .orig   (org[ax]),
            .dir    (dirv[ax]),
            .slab_t (t1[ax])
         );
      end
   endgenerate

   // Order each axis, then take the largest entry and the smallest exit.
   ord_type near_in;
   ord_type far_in;
   ord_type near_ff;
   ord_type far_ff;

   always_comb begin
      ord_type lo;
      ord_type hi;
      near_in = ORD_MIN;
      far_in  = ORD_MAX;
      for (int i = 0; i < 3; i++) begin
         lo = (t0[i] < t1[i]) ? t0[i] : t1[i];
         hi = (t0[i] < t1[i]) ? t1[i] : t0[i];
         if (lo > near_in) begin
            near_in = lo;
         end
         if (hi < far_in) begin
            far_in = hi;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         near_ff <= near_in;
         far_ff  <= far_in;
      end
   end

   // Back from offset binary to two's complement.
   assign rsp_t_near = coord_type'(near_ff ^ ORD_HALF);
   assign rsp_t_far  = coord_type'(far_ff ^ ORD_HALF);

endmodule
